// ===== hw/rtl/bwu_pkg.sv =====
// Package for the batch weight update block: register indexes, update modes,
// Q16.16 constants, the sideband record of the secant divider and saturation.
// No dependencies.
package bwu_pkg;

    typedef enum logic [2:0] {
        REG_MODE,
        REG_SCALE,
        REG_MU,
        REG_DECAY,
        REG_SMIN,
        REG_SMAX,
        REG_GROW,
        REG_SHRINK
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_BATCH,
        MODE_QPROP,
        MODE_RPROP,
        MODE_NONE
    } mode_t;

    localparam int DIV_STAGES   = 31;
    localparam int SHRINK_ITERS = 16;

    localparam logic signed [31:0] QP_STEP_EPS = 32'sd65;
    localparam logic signed [31:0] SAT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN     = 32'sh8000_0000;

    localparam logic [30:0] ONE_Q16       = 31'd65536;
    localparam logic [30:0] SCALE_RESET   = 31'd45875;
    localparam logic [30:0] MU_RESET      = 31'd114688;
    localparam logic signed [31:0] DECAY_RESET = -32'sd7;
    localparam logic [30:0] SMIN_RESET    = 31'd0;
    localparam logic [30:0] SMAX_RESET    = 31'd3276800;
    localparam logic [30:0] GROW_RESET    = 31'd78643;
    localparam logic [30:0] SHRINK_RESET  = 31'd32768;
    localparam logic [15:0] QP_SHRINK_RESET = 16'd41704;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] w;
        logic signed [31:0] rw;
        logic signed [31:0] rslope;
        logic signed [31:0] rstep;
        logic signed [47:0] base;
        logic signed [47:0] mu_term;
        logic               add_mu;
        logic               add_sec;
        logic               neg;
        logic               ovf;
        logic               den_zero;
        logic               num_pos;
        logic               num_neg;
    } side_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > 50'sd2147483647)
            r = SAT_MAX;
        else if (v < -50'sd2147483648)
            r = SAT_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/bwu_ifs.sv =====
// Channel interfaces of the batch weight update block: item in, result out.
// No dependencies.
interface bwu_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] weight_in;
    logic signed [31:0] slope_in;
    logic signed [31:0] prior_slope_in;
    logic signed [31:0] prior_step_in;

    modport source (output valid, weight_in, slope_in, prior_slope_in, prior_step_in,
                    input ready);
    modport sink (input valid, weight_in, slope_in, prior_slope_in, prior_step_in,
                  output ready);
endinterface

interface bwu_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] weight_out;
    logic signed [31:0] prior_slope_out;
    logic signed [31:0] prior_step_out;

    modport source (output valid, weight_out, prior_slope_out, prior_step_out,
                    input ready);
    modport sink (input valid, weight_out, prior_slope_out, prior_step_out,
                  output ready);
endinterface

// ===== hw/rtl/bwu_shrink_div.sv =====
// Iterative divider that derives the quickprop shrink factor mu/(1+mu).
// Depends on bwu_pkg.
module bwu_shrink_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [30:0] mu,
    output logic        busy,
    output logic [15:0] shrink
);
    import bwu_pkg::*;

    logic [31:0] rem_reg, rem_next;
    logic [31:0] den_reg;
    logic [15:0] q_reg, q_next;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] trial;
    logic        ge;

    always_comb
    begin
        trial    = {rem_reg, 1'b0};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
        q_next   = {q_reg[14:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            q_reg    <= QP_SHRINK_RESET;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'(SHRINK_ITERS);
            q_reg    <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, mu};
            den_reg <= {1'b0, mu} + {1'b0, ONE_Q16};
        end
        else if (busy_reg)
            rem_reg <= rem_next;
    end

    assign busy   = busy_reg;
    assign shrink = q_reg;

endmodule

// ===== hw/rtl/bwu_sec_div.sv =====
// Pipelined restoring divider for the quickprop secant term, one quotient
// bit per stage, with a sideband record that travels alongside. Uses bwu_pkg.
module bwu_sec_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [31:0]                       in_rem,
    input  logic [31:0]                       in_den,
    input  logic [bwu_pkg::DIV_STAGES-1:0]    in_low,
    input  bwu_pkg::side_t                    in_side,
    output logic                              out_valid,
    output logic [bwu_pkg::DIV_STAGES-1:0]    out_q,
    output bwu_pkg::side_t                    out_side
);
    import bwu_pkg::*;

    logic                  v_reg    [DIV_STAGES];
    logic [31:0]           rem_reg  [DIV_STAGES];
    logic [31:0]           den_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] low_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] q_reg    [DIV_STAGES];
    side_t                 side_reg [DIV_STAGES];

    logic [31:0]           rem_src  [DIV_STAGES];
    logic [31:0]           den_src  [DIV_STAGES];
    logic [DIV_STAGES-1:0] low_src  [DIV_STAGES];
    logic [DIV_STAGES-1:0] q_src    [DIV_STAGES];
    logic [32:0]           trial    [DIV_STAGES];
    logic                  ge       [DIV_STAGES];
    logic [31:0]           rem_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] low_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] q_next   [DIV_STAGES];

    always_comb
    begin
        rem_src[0] = in_rem;
        den_src[0] = in_den;
        low_src[0] = in_low;
        q_src[0]   = '0;
        for (int i = 1; i < DIV_STAGES; i++)
        begin
            rem_src[i] = rem_reg[i-1];
            den_src[i] = den_reg[i-1];
            low_src[i] = low_reg[i-1];
            q_src[i]   = q_reg[i-1];
        end
        for (int i = 0; i < DIV_STAGES; i++)
        begin
            trial[i]    = {rem_src[i], low_src[i][DIV_STAGES-1]};
            ge[i]       = trial[i] >= {1'b0, den_src[i]};
            rem_next[i] = ge[i] ? 32'(trial[i] - {1'b0, den_src[i]}) : trial[i][31:0];
            low_next[i] = {low_src[i][DIV_STAGES-2:0], 1'b0};
            q_next[i]   = {q_src[i][DIV_STAGES-2:0], ge[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < DIV_STAGES; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int i = 1; i < DIV_STAGES; i++)
                side_reg[i] <= side_reg[i-1];
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                rem_reg[i]  <= rem_next[i];
                den_reg[i]  <= den_src[i];
                low_reg[i]  <= low_next[i];
                q_reg[i]    <= q_next[i];
            end
        end
    end

    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_q     = q_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule

// ===== hw/rtl/batch_weight_update_rprop_qprop.sv =====
// Throughput is one item per cycle while the output is not stalled and no shrink
// factor is being derived, set by the 38-stage pipeline and its 31 divider stages.
// A stalled output holds the whole pipeline; bubbles are not squeezed out.
// Writing qprop_mu holds input ready low while mu/(1+mu) is derived.
// Reset clears all valid bits and loads the default register values.
// Depends on bwu_pkg, bwu_ifs, bwu_shrink_div and bwu_sec_div.
module batch_weight_update_rprop_qprop (
    input  logic       clk,
    input  logic       rst_n,
    bwu_in_if.sink     in_ch,
    bwu_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import bwu_pkg::*;

    mode_t              mode_reg;
    logic [30:0]        scale_reg, mu_reg, smin_reg, smax_reg, grow_reg, shrink_reg;
    logic signed [31:0] decay_reg;
    logic [15:0]        qp_shrink;
    logic               busy;
    logic               en;
    logic               acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RPROP;
            scale_reg  <= SCALE_RESET;
            mu_reg     <= MU_RESET;
            decay_reg  <= DECAY_RESET;
            smin_reg   <= SMIN_RESET;
            smax_reg   <= SMAX_RESET;
            grow_reg   <= GROW_RESET;
            shrink_reg <= SHRINK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_MODE:   mode_reg   <= mode_t'(cfg_data[1:0]);
                REG_SCALE:  scale_reg  <= cfg_data[30:0];
                REG_MU:     mu_reg     <= cfg_data[30:0];
                REG_DECAY:  decay_reg  <= cfg_data;
                REG_SMIN:   smin_reg   <= cfg_data[30:0];
                REG_SMAX:   smax_reg   <= cfg_data[30:0];
                REG_GROW:   grow_reg   <= cfg_data[30:0];
                REG_SHRINK: shrink_reg <= cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    bwu_shrink_div u_shrink (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_we && (cfg_idx_t'(cfg_index) == REG_MU)),
        .mu     (cfg_data[30:0]),
        .busy   (busy),
        .shrink (qp_shrink)
    );

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, vf_reg, vo_reg;
    logic div_v;

    assign en           = !vo_reg || out_ch.ready;
    assign in_ch.ready  = en && !busy;
    assign acc          = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vf_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= acc;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vf_reg <= div_v;
            vo_reg <= vf_reg;
        end
    end

    // Stage 0: input capture.
    mode_t              m0_reg;
    logic signed [31:0] w0_reg, s0_reg, pl0_reg, ps0_reg;

    // Stage 1: first products.
    mode_t              m1_reg;
    logic signed [31:0] w1_reg, s1_reg, pl1_reg, ps1_reg;
    logic signed [63:0] prod_b1_reg, prod_d1_reg, prod_b1_next, prod_d1_next;
    logic [61:0]        prod_g1_reg, prod_s1_reg, prod_g1_next, prod_s1_next;
    logic               agree1_reg, agree1_next;
    logic [30:0]        p_mag;

    always_comb
    begin
        p_mag        = (ps0_reg > $signed({1'b0, smin_reg})) ? ps0_reg[30:0] : smin_reg;
        prod_b1_next = s0_reg * $signed({1'b0, scale_reg});
        prod_d1_next = decay_reg * w0_reg;
        prod_g1_next = p_mag * grow_reg;
        prod_s1_next = p_mag * shrink_reg;
        agree1_next  = !((s0_reg < 0 && pl0_reg > 0) || (s0_reg > 0 && pl0_reg < 0));
    end

    // Stage 2: batch and rprop finish here, quickprop forms its slope.
    mode_t              m2_reg;
    logic signed [31:0] w2_reg, pl2_reg, ps2_reg;
    logic signed [31:0] rw2_reg, rslope2_reg, rstep2_reg;
    logic signed [31:0] rw2_next, rslope2_next, rstep2_next;
    logic [45:0]        grow_step, shrink_step, rp_step;
    logic signed [31:0] rp_step_sat, rp_cs;

    always_comb
    begin
        grow_step   = prod_g1_reg[61:16];
        shrink_step = prod_s1_reg[61:16];
        if (agree1_reg)
        begin
            rp_step = (grow_step > {15'b0, smax_reg}) ? {15'b0, smax_reg} : grow_step;
            rp_cs   = s1_reg;
        end
        else
        begin
            rp_step = (shrink_step < {15'b0, smin_reg}) ? {15'b0, smin_reg} : shrink_step;
            rp_cs   = '0;
        end
        rp_step_sat = (rp_step[45:31] != '0) ? SAT_MAX : $signed({1'b0, rp_step[30:0]});

        rw2_next     = w1_reg;
        rslope2_next = pl1_reg;
        rstep2_next  = ps1_reg;
        case (m1_reg)
            MODE_BATCH:
            begin
                rw2_next = sat32(50'(w1_reg) + 50'(prod_b1_reg >>> 16));
            end
            MODE_QPROP:
            begin
                rslope2_next = sat32(50'(s1_reg) + 50'(prod_d1_reg >>> 16));
            end
            MODE_RPROP:
            begin
                rslope2_next = rp_cs;
                rstep2_next  = rp_step_sat;
                if (rp_cs > 0)
                    rw2_next = sat32(50'(w1_reg) + 50'(rp_step_sat));
                else if (rp_cs < 0)
                    rw2_next = sat32(50'(w1_reg) - 50'(rp_step_sat));
            end
            default: ;
        endcase
    end

    // Stage 3: quickprop products.
    mode_t              m3_reg;
    logic signed [31:0] w3_reg, ps3_reg, rw3_reg, rslope3_reg, rstep3_reg;
    logic signed [63:0] pstep3_reg, pmu3_reg, num3_reg;
    logic signed [63:0] pstep3_next, pmu3_next, num3_next;
    logic signed [49:0] rhs3_reg, rhs3_next;
    logic signed [32:0] den3_reg, den3_next;

    always_comb
    begin
        pstep3_next = $signed({1'b0, scale_reg}) * rslope2_reg;
        rhs3_next   = $signed({1'b0, qp_shrink}) * pl2_reg;
        pmu3_next   = $signed({1'b0, mu_reg}) * ps2_reg;
        num3_next   = ps2_reg * rslope2_reg;
        den3_next   = 33'(pl2_reg) - 33'(rslope2_reg);
    end

    // Stage 4: branch decision and divider setup.
    logic [31:0]           rem4_reg, den4_reg, rem4_next, den4_next;
    logic [DIV_STAGES-1:0] low4_reg, low4_next;
    side_t                 side4_reg, side4_next;
    logic signed [49:0]    lhs;
    logic signed [47:0]    step0;
    logic [62:0]           num_mag;
    logic [31:0]           num_hi;

    always_comb
    begin
        lhs     = 50'($signed({rslope3_reg, 16'h0000}));
        step0   = 48'(pstep3_reg >>> 16);
        num_mag = num3_reg[63] ? 63'(-num3_reg) : num3_reg[62:0];
        den4_next = den3_reg[32] ? 32'(-den3_reg) : den3_reg[31:0];
        num_hi    = num_mag[62:31];
        rem4_next = num_hi;
        low4_next = num_mag[DIV_STAGES-1:0];

        side4_next.mode     = m3_reg;
        side4_next.w        = w3_reg;
        side4_next.rw       = rw3_reg;
        side4_next.rslope   = rslope3_reg;
        side4_next.rstep    = rstep3_reg;
        side4_next.mu_term  = 48'(pmu3_reg >>> 16);
        side4_next.ovf      = num_hi >= den4_next;
        side4_next.neg      = num3_reg[63] ^ den3_reg[32];
        side4_next.den_zero = den3_reg == '0;
        side4_next.num_pos  = !num3_reg[63] && (num3_reg != '0);
        side4_next.num_neg  = num3_reg[63];
        side4_next.base     = step0;
        side4_next.add_mu   = 1'b0;
        side4_next.add_sec  = 1'b0;
        if (ps3_reg > QP_STEP_EPS)
        begin
            if (rslope3_reg <= 0)
                side4_next.base = '0;
            side4_next.add_mu  = lhs > rhs3_reg;
            side4_next.add_sec = !(lhs > rhs3_reg);
        end
        else if (ps3_reg < -QP_STEP_EPS)
        begin
            if (rslope3_reg >= 0)
                side4_next.base = '0;
            side4_next.add_mu  = lhs < rhs3_reg;
            side4_next.add_sec = !(lhs < rhs3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_reg      <= mode_reg;
            w0_reg      <= in_ch.weight_in;
            s0_reg      <= in_ch.slope_in;
            pl0_reg     <= in_ch.prior_slope_in;
            ps0_reg     <= in_ch.prior_step_in;

            m1_reg      <= m0_reg;
            w1_reg      <= w0_reg;
            s1_reg      <= s0_reg;
            pl1_reg     <= pl0_reg;
            ps1_reg     <= ps0_reg;
            prod_b1_reg <= prod_b1_next;
            prod_d1_reg <= prod_d1_next;
            prod_g1_reg <= prod_g1_next;
            prod_s1_reg <= prod_s1_next;
            agree1_reg  <= agree1_next;

            m2_reg      <= m1_reg;
            w2_reg      <= w1_reg;
            pl2_reg     <= pl1_reg;
            ps2_reg     <= ps1_reg;
            rw2_reg     <= rw2_next;
            rslope2_reg <= rslope2_next;
            rstep2_reg  <= rstep2_next;

            m3_reg      <= m2_reg;
            w3_reg      <= w2_reg;
            ps3_reg     <= ps2_reg;
            rw3_reg     <= rw2_reg;
            rslope3_reg <= rslope2_reg;
            rstep3_reg  <= rstep2_reg;
            pstep3_reg  <= pstep3_next;
            pmu3_reg    <= pmu3_next;
            num3_reg    <= num3_next;
            rhs3_reg    <= rhs3_next;
            den3_reg    <= den3_next;

            rem4_reg    <= rem4_next;
            den4_reg    <= den4_next;
            low4_reg    <= low4_next;
            side4_reg   <= side4_next;
        end
    end

    logic [DIV_STAGES-1:0] div_q;
    side_t                 div_side;

    bwu_sec_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_rem    (rem4_reg),
        .in_den    (den4_reg),
        .in_low    (low4_reg),
        .in_side   (side4_reg),
        .out_valid (div_v),
        .out_q     (div_q),
        .out_side  (div_side)
    );

    // Final stages: secant saturation, step sum, weight sum.
    mode_t              mf_reg;
    logic signed [31:0] wf_reg, rwf_reg, rslopef_reg, rstepf_reg, qstepf_reg, qstepf_next;
    logic signed [31:0] sec;
    logic signed [47:0] term;
    logic signed [31:0] wo_reg, so_reg, po_reg, wo_next, so_next, po_next;

    always_comb
    begin
        if (div_side.den_zero)
            sec = div_side.num_pos ? SAT_MAX : (div_side.num_neg ? SAT_MIN : '0);
        else if (div_side.ovf)
            sec = div_side.neg ? SAT_MIN : SAT_MAX;
        else if (div_side.neg)
            sec = -$signed({1'b0, div_q});
        else
            sec = $signed({1'b0, div_q});

        if (div_side.add_mu)
            term = div_side.mu_term;
        else if (div_side.add_sec)
            term = 48'(sec);
        else
            term = '0;
        qstepf_next = sat32(50'(div_side.base) + 50'(term));
    end

    always_comb
    begin
        if (mf_reg == MODE_QPROP)
        begin
            wo_next = sat32(50'(wf_reg) + 50'(qstepf_reg));
            so_next = rslopef_reg;
            po_next = qstepf_reg;
        end
        else
        begin
            wo_next = rwf_reg;
            so_next = rslopef_reg;
            po_next = rstepf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mf_reg      <= div_side.mode;
            wf_reg      <= div_side.w;
            rwf_reg     <= div_side.rw;
            rslopef_reg <= div_side.rslope;
            rstepf_reg  <= div_side.rstep;
            qstepf_reg  <= qstepf_next;
            wo_reg      <= wo_next;
            so_reg      <= so_next;
            po_reg      <= po_next;
        end
    end

    assign out_ch.valid           = vo_reg;
    assign out_ch.weight_out      = wo_reg;
    assign out_ch.prior_slope_out = so_reg;
    assign out_ch.prior_step_out  = po_reg;

endmodule

// ===== hw/rtl/bwu_checker.sv =====
// Port-level checks for the batch weight update block, bound to the top level.
// Depends on bwu_pkg and batch_weight_update_rprop_qprop.
module bwu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_w,
    input logic [31:0] out_slope,
    input logic [31:0] out_step,
    input logic        cfg_we,
    input logic [2:0]  cfg_index
);
    import bwu_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result withdrawn before its transfer.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_w) && $stable(out_slope) && $stable(out_step))
        else $error("Stalled result changed.");

    a_mu_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_idx_t'(cfg_index) == REG_MU) |=> !in_ready)
        else $error("Input taken while the shrink factor is being derived.");

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("Result shown during reset.");

endmodule

bind batch_weight_update_rprop_qprop bwu_checker u_bwu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_w     (out_ch.weight_out),
    .out_slope (out_ch.prior_slope_out),
    .out_step  (out_ch.prior_step_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index)
);
